// ----- rtl/nbm4_pkg.sv -----
// ----------------------------------------------------------------------------
// nbm4_pkg
// Shared types and constants for the degree-4 twisted-ring base multiplier.
// ----------------------------------------------------------------------------
package nbm4_pkg;

    localparam int COEF_W   = 16;
    localparam int NCOEF    = 4;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int IN_W     = 10 * COEF_W;
    localparam int OUT_W    = NCOEF * COEF_W;
    localparam int MONT_LAT = 3;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t [NCOEF-1:0]        coef_vec_t;
    typedef coef_vec_t [NCOEF-1:0]    coef_mat_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // modulus, its inverse mod 2^16, and the final scaling factor pair
    localparam coef_t       MOD_Q    = 16'sd3457;
    localparam logic [15:0] MOD_QINV = 16'd12929;
    localparam coef_t       RSQ_F    = 16'sd867;
    localparam coef_t       RSQ_FQ   = 16'sd2787;

endpackage

// ----- rtl/nbm4_mont_array.sv -----
// ----------------------------------------------------------------------------
// nbm4_mont_array
// Three-stage array of sixteen Montgomery multipliers, one per a_i * b_j pair.
// ----------------------------------------------------------------------------
module nbm4_mont_array (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  nbm4_pkg::coef_vec_t a,
    input  nbm4_pkg::coef_vec_t b,
    output logic              out_valid,
    output nbm4_pkg::coef_mat_t m
);
    import nbm4_pkg::*;

    prod_t     p_reg   [NCOEF][NCOEF];
    coef_t     phi_reg [NCOEF][NCOEF];
    coef_t     t_reg   [NCOEF][NCOEF];
    prod_t     tq      [NCOEF][NCOEF];
    coef_mat_t m_reg;
    logic      v1_reg, v2_reg, v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < NCOEF; i++) begin
            for (int j = 0; j < NCOEF; j++) begin
                tq[i][j] = prod_t'(t_reg[i][j]) * prod_t'(MOD_Q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NCOEF; i++) begin
                for (int j = 0; j < NCOEF; j++) begin
                    // full signed product
                    p_reg[i][j]   <= prod_t'($signed(a[i])) * prod_t'($signed(b[j]));
                    // only the low half matters for the reduction factor
                    phi_reg[i][j] <= p_reg[i][j][PROD_W-1:COEF_W];
                    t_reg[i][j]   <= coef_t'(p_reg[i][j][COEF_W-1:0] * MOD_QINV);
                    m_reg[i][j]   <= phi_reg[i][j] - tq[i][j][PROD_W-1:COEF_W];
                end
            end
        end
    end

    assign out_valid = v3_reg;
    assign m         = m_reg;

endmodule

// ----- rtl/nbm4_fixd.sv -----
// ----------------------------------------------------------------------------
// nbm4_fixd
// Two-stage multiply by a factor in Montgomery form on four lanes,
// plus a per-lane addend.
// ----------------------------------------------------------------------------
module nbm4_fixd (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  nbm4_pkg::coef_vec_t x,
    input  nbm4_pkg::coef_t     f,
    input  nbm4_pkg::coef_t     fq,
    input  nbm4_pkg::coef_vec_t addend,
    output logic                out_valid,
    output nbm4_pkg::coef_vec_t y
);
    import nbm4_pkg::*;

    prod_t     hp_next [NCOEF];
    coef_t     lq_next [NCOEF];
    prod_t     hp_reg  [NCOEF];
    coef_t     lq_reg  [NCOEF];
    coef_t     add_reg [NCOEF];
    prod_t     tq      [NCOEF];
    coef_vec_t y_next;
    coef_vec_t y_reg;
    logic      va_reg, vb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < NCOEF; k++) begin
            hp_next[k] = prod_t'($signed(x[k])) * prod_t'(f);
            lq_next[k] = coef_t'(x[k] * fq);
            tq[k]      = prod_t'(lq_reg[k]) * prod_t'(MOD_Q);
            y_next[k]  = hp_reg[k][PROD_W-1:COEF_W] - tq[k][PROD_W-1:COEF_W] + add_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NCOEF; k++) begin
                hp_reg[k]  <= hp_next[k];
                lq_reg[k]  <= lq_next[k];
                add_reg[k] <= addend[k];
            end
            y_reg <= y_next;
        end
    end

    assign out_valid = vb_reg;
    assign y         = y_reg;

endmodule

// ----- rtl/nbm4_out_skid.sv -----
// ----------------------------------------------------------------------------
// nbm4_out_skid
// Output register with one skid entry; ready toward the pipeline is registered.
// ----------------------------------------------------------------------------
module nbm4_out_skid (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [nbm4_pkg::OUT_W-1:0]    in_data,
    output logic                          in_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nbm4_pkg::OUT_W-1:0]    m_tdata
);
    import nbm4_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic [OUT_W-1:0] skid_data_reg, skid_data_next;
    logic             take;

    assign take = in_valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            out_valid_next  = skid_valid_reg || take;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (take) begin
            // output is held, park the item
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- rtl/ntt_basemul_degree4_montgomery_unit.sv -----
// ----------------------------------------------------------------------------
// ntt_basemul_degree4_montgomery_unit
// Product of two degree-3 polynomials modulo (x^4 - twist), signed Montgomery
// arithmetic modulo 3457, final scaling by the 867/2787 factor pair.
// ----------------------------------------------------------------------------
//  channel  dir  tdata bits  contents (lowest bits first)
//  s_       in   160         a_coef0..3, b_coef0..3, twist, twist_qinv
//  m_       out  64          c_coef0..3
//
//  one item per cycle while the skid entry is free
//  pipeline: 3 stages Montgomery products, 1 stage sums, 2 stages twist, 2 stages
//  final scaling, then the output register
//  the whole pipeline halts while the skid entry is occupied; s_tready is registered
//  reset clears valid bits only
// ----------------------------------------------------------------------------
module ntt_basemul_degree4_montgomery_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a_coef0, a_coef1, a_coef2, a_coef3, b_coef0, b_coef1, b_coef2, b_coef3,
    // twist, twist_qinv
    input  logic [nbm4_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // c_coef0, c_coef1, c_coef2, c_coef3
    output logic [nbm4_pkg::OUT_W-1:0]     m_tdata
);
    import nbm4_pkg::*;

    logic      en;
    coef_vec_t a_coef, b_coef;
    coef_t     twist, twist_qinv;

    logic      mont_valid;
    coef_mat_t m;

    coef_t     tw_dly_reg  [MONT_LAT];
    coef_t     twq_dly_reg [MONT_LAT];

    coef_vec_t sum_reg, sum_next;
    coef_vec_t add_reg, add_next;
    coef_t     tw_reg, twq_reg;
    logic      v4_reg;

    logic      tw_valid;
    coef_vec_t tw_out;
    logic      fin_valid;
    coef_vec_t fin_out;

    always_comb begin
        for (int k = 0; k < NCOEF; k++) begin
            a_coef[k] = s_tdata[k*COEF_W +: COEF_W];
            b_coef[k] = s_tdata[(NCOEF+k)*COEF_W +: COEF_W];
        end
        twist      = s_tdata[2*NCOEF*COEF_W +: COEF_W];
        twist_qinv = s_tdata[(2*NCOEF+1)*COEF_W +: COEF_W];
    end

    nbm4_mont_array u_mont (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .a         (a_coef),
        .b         (b_coef),
        .out_valid (mont_valid),
        .m         (m)
    );

    // twist rides alongside the multiplier array
    always_ff @(posedge aclk) begin
        if (en) begin
            tw_dly_reg[0]  <= twist;
            twq_dly_reg[0] <= twist_qinv;
            for (int d = 1; d < MONT_LAT; d++) begin
                tw_dly_reg[d]  <= tw_dly_reg[d-1];
                twq_dly_reg[d] <= twq_dly_reg[d-1];
            end
        end
    end

    // lanes 0..2 get the wrapped part scaled by twist; lane 3 has none,
    // a zero operand leaves only its addend
    always_comb begin
        sum_next[0] = m[1][3] + m[2][2] + m[3][1];
        sum_next[1] = m[2][3] + m[3][2];
        sum_next[2] = m[3][3];
        sum_next[3] = '0;
        add_next[0] = m[0][0];
        add_next[1] = m[0][1] + m[1][0];
        add_next[2] = m[0][2] + m[1][1] + m[2][0];
        add_next[3] = m[0][3] + m[1][2] + m[2][1] + m[3][0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= mont_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            add_reg <= add_next;
            tw_reg  <= tw_dly_reg[MONT_LAT-1];
            twq_reg <= twq_dly_reg[MONT_LAT-1];
        end
    end

    nbm4_fixd u_twist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .x         (sum_reg),
        .f         (tw_reg),
        .fq        (twq_reg),
        .addend    (add_reg),
        .out_valid (tw_valid),
        .y         (tw_out)
    );

    nbm4_fixd u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (tw_valid),
        .x         (tw_out),
        .f         (RSQ_F),
        .fq        (RSQ_FQ),
        .addend    ('0),
        .out_valid (fin_valid),
        .y         (fin_out)
    );

    nbm4_out_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fin_valid),
        .in_data  (OUT_W'(fin_out)),
        .in_ready (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = en;

endmodule

// ----- rtl/nbm4_checker.sv -----
// ----------------------------------------------------------------------------
// nbm4_checker
// Port-level checks for the base multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module nbm4_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [nbm4_pkg::OUT_W-1:0] m_tdata
);
    import nbm4_pkg::*;

    // input side only stalls when a result is waiting
    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result pending");

    // ready drops only after the output was refused
    a_ready_fall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready fell without output backpressure");

    // nothing comes out right after reset
    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result present right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind ntt_basemul_degree4_montgomery_unit nbm4_checker u_nbm4_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
